[rtl/lph_pkg.sv]
// shared types, constants and codes for the looping playhead
package lph_pkg;

	localparam int TIME_WIDTH      = 32;
	localparam int LOOP_WIDTH      = 16;
	localparam int SPEED_WIDTH     = 16;
	localparam int SPEED_FRAC      = 8;
	localparam int REG_INDEX_WIDTH = 3;
	localparam int CFG_WIDTH       = (TIME_WIDTH > LOOP_WIDTH) ?
		((TIME_WIDTH > SPEED_WIDTH) ? TIME_WIDTH : SPEED_WIDTH) :
		((LOOP_WIDTH > SPEED_WIDTH) ? LOOP_WIDTH : SPEED_WIDTH);
	localparam int PROD_WIDTH      = TIME_WIDTH + SPEED_WIDTH;
	localparam int DIV_COUNT_WIDTH = $clog2(TIME_WIDTH + 1);

	typedef logic signed [TIME_WIDTH-1:0]  time_t;
	typedef logic signed [LOOP_WIDTH-1:0]  loop_t;
	typedef logic signed [SPEED_WIDTH-1:0] speed_t;

	// action codes
	localparam logic [1:0] ACT_ADVANCE = 2'd0;
	localparam logic [1:0] ACT_SEEK    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	typedef enum logic [REG_INDEX_WIDTH-1:0] {
		REG_RANGE_START = 3'd0,
		REG_RANGE_END   = 3'd1,
		REG_LOOP_FIRST  = 3'd2,
		REG_LOOP_LAST   = 3'd3,
		REG_LOOP_COUNT  = 3'd4,
		REG_PLAY_SPEED  = 3'd5
	} reg_index_t;

	// reset values of the registers
	localparam time_t  RANGE_START_RST = TIME_WIDTH'(-65536);
	localparam time_t  RANGE_END_RST   = '0;
	localparam time_t  LOOP_FIRST_RST  = TIME_WIDTH'(-65536);
	localparam time_t  LOOP_LAST_RST   = '0;
	localparam loop_t  LOOP_COUNT_RST  = '0;
	localparam speed_t PLAY_SPEED_RST  = SPEED_WIDTH'(256);

	localparam time_t TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
	localparam time_t TIME_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [1:0] action;
		time_t      step;
		time_t      position;
	} item_t;

	typedef struct packed {
		time_t play_time;
		loop_t loops_left;
		logic  stopped;
		logic  changed;
		logic  collapsed;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic geo1;
		logic geo2;
		logic geo3;
		logic eval;
		logic div_start;
		logic wrap;
		logic fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

[rtl/lph_mod.sv]
// iterative restoring remainder unit, one quotient bit per cycle
module lph_mod (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lph_pkg::TIME_WIDTH-1:0]    dividend,
	input  logic [lph_pkg::TIME_WIDTH-1:0]    divisor,
	output logic                              done,
	output logic [lph_pkg::TIME_WIDTH-1:0]    remainder
);
	import lph_pkg::*;

	logic [TIME_WIDTH-1:0]      rem_q;
	logic [TIME_WIDTH-1:0]      sh_q;
	logic [TIME_WIDTH-1:0]      d_q;
	logic [DIV_COUNT_WIDTH-1:0] cnt_q;
	logic                       run_q;
	logic [TIME_WIDTH:0]        trial;
	logic [TIME_WIDTH:0]        diff;

	assign trial = {rem_q, sh_q[TIME_WIDTH-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
		end else if (start) begin
			cnt_q <= DIV_COUNT_WIDTH'(TIME_WIDTH);
			run_q <= 1'b1;
		end else if (run_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= dividend;
			d_q   <= divisor;
		end else if (run_q && cnt_q != '0) begin
			// keep the difference unless it borrowed
			rem_q <= diff[TIME_WIDTH] ? trial[TIME_WIDTH-1:0] : diff[TIME_WIDTH-1:0];
			sh_q  <= sh_q << 1;
		end
	end

	assign done      = run_q && (cnt_q == '0);
	assign remainder = rem_q;

endmodule

[rtl/lph_ctrl.sv]
// sequencing state machine for the looping playhead
module lph_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  lph_pkg::stat_t stat,
	output lph_pkg::cmd_t  cmd
);
	import lph_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_GEO1 = 7'b0000010,
		ST_GEO2 = 7'b0000100,
		ST_GEO3 = 7'b0001000,
		ST_EVAL = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_GEO1;
				end
			end
			ST_GEO1: begin
				cmd.geo1 = 1'b1;
				state_d  = ST_GEO2;
			end
			ST_GEO2: begin
				cmd.geo2 = 1'b1;
				state_d  = ST_GEO3;
			end
			ST_GEO3: begin
				cmd.geo3 = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.wrap = 1'b1;
					state_d  = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready = (state_q == ST_IDLE);

endmodule

[rtl/lph_dpath.sv]
// registers, geometry, speed product and time update of the looping playhead
module lph_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [lph_pkg::REG_INDEX_WIDTH-1:0] wr_index,
	input  logic [lph_pkg::CFG_WIDTH-1:0]       wr_data,
	input  lph_pkg::item_t                      item,
	input  lph_pkg::cmd_t                       cmd,
	output lph_pkg::stat_t                      stat,
	output logic                                result_valid,
	input  logic                                result_ready,
	output lph_pkg::result_t                    result
);
	import lph_pkg::*;

	localparam int QW = PROD_WIDTH - SPEED_FRAC;

	function automatic time_t clamp_t(input time_t v, input time_t lo, input time_t hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// e + s - t, only used with s <= t <= e so the result is in range
	function automatic time_t mirror_t(input time_t t, input time_t s, input time_t e);
		logic signed [TIME_WIDTH+1:0] m;
		m = {{2{e[TIME_WIDTH-1]}}, e} + {{2{s[TIME_WIDTH-1]}}, s}
			- {{2{t[TIME_WIDTH-1]}}, t};
		return time_t'(m[TIME_WIDTH-1:0]);
	endfunction

	// configuration registers
	time_t  rs_q, re_q, lf_q, ll_q;
	loop_t  lcnt_q;
	speed_t spd_q;

	// architectural state
	time_t  cur_q;
	loop_t  loops_q;

	// per item working registers
	item_t                 item_q;
	time_t                 s_q, e_q, lo_q, hi_q;
	logic                  rev_q;
	logic [PROD_WIDTH-1:0] prod_q;
	logic                  neg_q;
	time_t                 lsc_q, lec_q, t0_q, pc_q, sc_q;
	time_t                 ls_q, le_q, pm_q, tsum_q;
	time_t                 t_q;
	loop_t                 lw_q;
	logic                  collapsed_q;
	result_t               result_q;
	logic                  result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q   <= RANGE_START_RST;
			re_q   <= RANGE_END_RST;
			lf_q   <= LOOP_FIRST_RST;
			ll_q   <= LOOP_LAST_RST;
			lcnt_q <= LOOP_COUNT_RST;
			spd_q  <= PLAY_SPEED_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RANGE_START: rs_q   <= wr_data[TIME_WIDTH-1:0];
				REG_RANGE_END:   re_q   <= wr_data[TIME_WIDTH-1:0];
				REG_LOOP_FIRST:  lf_q   <= wr_data[TIME_WIDTH-1:0];
				REG_LOOP_LAST:   ll_q   <= wr_data[TIME_WIDTH-1:0];
				REG_LOOP_COUNT:  lcnt_q <= wr_data[LOOP_WIDTH-1:0];
				REG_PLAY_SPEED:  spd_q  <= wr_data[SPEED_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage one: sort, magnitudes and product
	logic [TIME_WIDTH-1:0]  step_mag;
	logic [SPEED_WIDTH-1:0] spd_mag;

	assign step_mag = item_q.step[TIME_WIDTH-1] ? (~item_q.step + 1'b1) : item_q.step;
	assign spd_mag  = spd_q[SPEED_WIDTH-1] ? (~spd_q + 1'b1) : spd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.geo1) begin
			s_q    <= (rs_q < re_q) ? rs_q : re_q;
			e_q    <= (rs_q < re_q) ? re_q : rs_q;
			lo_q   <= (lf_q < ll_q) ? lf_q : ll_q;
			hi_q   <= (lf_q < ll_q) ? ll_q : lf_q;
			rev_q  <= (lf_q > ll_q);
			prod_q <= PROD_WIDTH'(step_mag) * PROD_WIDTH'(spd_mag);
			neg_q  <= item_q.step[TIME_WIDTH-1] ^ spd_q[SPEED_WIDTH-1];
		end
	end

	// stage two: clamps and product saturation
	logic [QW-1:0] q;
	logic          q_big;
	logic          q_min;
	time_t         sc_d;

	assign q     = prod_q[PROD_WIDTH-1:SPEED_FRAC];
	assign q_big = |q[QW-1:TIME_WIDTH-1];
	assign q_min = (q == (QW'(1) << (TIME_WIDTH-1)));

	always_comb begin
		if (!neg_q) begin
			sc_d = q_big ? TIME_MAX : time_t'(q[TIME_WIDTH-1:0]);
		end else begin
			sc_d = (q_big && !q_min) ? TIME_MIN
				: time_t'(~q[TIME_WIDTH-1:0] + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.geo2) begin
			lsc_q <= clamp_t(lo_q, s_q, e_q);
			lec_q <= clamp_t(hi_q, s_q, e_q);
			t0_q  <= clamp_t(cur_q, s_q, e_q);
			pc_q  <= clamp_t(item_q.position, s_q, e_q);
			sc_q  <= sc_d;
		end
	end

	// stage three: mirror loop points and target, saturating add
	logic signed [TIME_WIDTH:0] sum;
	time_t                      sum_sat;

	assign sum = {t0_q[TIME_WIDTH-1], t0_q} + {sc_q[TIME_WIDTH-1], sc_q};

	always_comb begin
		if (sum[TIME_WIDTH] != sum[TIME_WIDTH-1]) begin
			sum_sat = sum[TIME_WIDTH] ? TIME_MIN : TIME_MAX;
		end else begin
			sum_sat = sum[TIME_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.geo3) begin
			ls_q   <= rev_q ? mirror_t(lec_q, s_q, e_q) : lsc_q;
			le_q   <= rev_q ? mirror_t(lsc_q, s_q, e_q) : lec_q;
			pm_q   <= rev_q ? mirror_t(pc_q, s_q, e_q) : pc_q;
			tsum_q <= sum_sat;
		end
	end

	// evaluation: end clamp, loop wrap, seek and restart
	logic [TIME_WIDTH-1:0] len;
	logic [TIME_WIDTH-1:0] over;
	logic                  above;
	logic                  loops_zero;
	logic                  div_done;
	logic [TIME_WIDTH-1:0] rem;

	assign len        = le_q - ls_q;
	assign over       = tsum_q - le_q;
	assign above      = (tsum_q > le_q);
	assign loops_zero = (loops_q == '0);

	lph_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (over),
		.divisor   (len),
		.done      (div_done),
		.remainder (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			// zero-length loop forces the end and clears the count
			collapsed_q <= (item_q.action == ACT_ADVANCE) && !loops_zero && above
				&& (len == '0);
			unique case (item_q.action)
				ACT_ADVANCE: begin
					if (loops_zero) begin
						t_q  <= clamp_t(tsum_q, s_q, e_q);
						lw_q <= loops_q;
					end else if (above) begin
						if (len == '0) begin
							t_q  <= e_q;
							lw_q <= '0;
						end else begin
							lw_q <= loops_q;
						end
					end else begin
						t_q  <= (tsum_q < s_q) ? s_q : tsum_q;
						lw_q <= loops_q;
					end
				end
				ACT_SEEK: begin
					t_q  <= pm_q;
					lw_q <= loops_q;
				end
				ACT_RESTART: begin
					t_q  <= pm_q;
					lw_q <= lcnt_q;
				end
				default: begin
					t_q  <= t0_q;
					lw_q <= loops_q;
				end
			endcase
		end else if (cmd.wrap) begin
			t_q <= time_t'(ls_q + rem);
			if (!lw_q[LOOP_WIDTH-1] && lw_q != '0) begin
				lw_q <= lw_q - 1'b1;
			end
		end
	end

	// commit and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q          <= RANGE_START_RST;
			loops_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				cur_q          <= t_q;
				loops_q        <= lw_q;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			result_q.play_time  <= rev_q ? mirror_t(t_q, s_q, e_q) : t_q;
			result_q.loops_left <= lw_q;
			result_q.stopped    <= (t_q >= e_q) && (lw_q == '0);
			result_q.changed    <= (t_q != cur_q);
			result_q.collapsed  <= collapsed_q;
		end
	end

	assign stat.need_div = (item_q.action == ACT_ADVANCE) && !loops_zero && above
		&& (len != '0);
	assign stat.div_done = div_done;
	assign stat.out_free = !result_valid_q || result_ready;

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/looping_playhead.sv]
// looping playhead top level: loop-point playback position counter
// sequence: the accepting edge loads the word, three geometry steps and an
//   evaluation follow, then the commit to result_valid once the output is free;
//   an advance that wraps waits for the remainder first; one word at a time; the
//   wrap remainder comes from a restoring unit taking one bit per cycle over 32 bits
// reset: registers take their defaults, time goes to the range start, loop
//   count to zero, output empty; no clearing pass
module looping_playhead (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                wr_en,
	input  logic [lph_pkg::REG_INDEX_WIDTH-1:0] wr_index,
	input  logic [lph_pkg::CFG_WIDTH-1:0]       wr_data,
	// incoming word: action, step and position
	input  logic                                item_valid,
	output logic                                item_ready,
	input  lph_pkg::item_t                      item,
	// outgoing word: time as seen outside and status flags
	output logic                                result_valid,
	input  logic                                result_ready,
	output lph_pkg::result_t                    result
);
	import lph_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// controller: one word in flight, idle -> three geometry steps -> evaluate
	// -> optional remainder wait -> commit once the output register is free
	lph_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: configuration, stored time and loop count, arithmetic and the
	// output register, which lets a new word in while a result waits
	lph_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[rtl/lph_checker.sv]
// port-level checks for the looping playhead and their binding
module lph_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  logic                                item_ready,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  lph_pkg::result_t                    result
);
	import lph_pkg::*;

	// one word at a time: taking a word closes the input side
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken twice in a row");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a collapsed loop leaves the count empty and the playhead stopped
	a_collapse_stops: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.collapsed |-> result.stopped && result.loops_left == '0)
		else $error("collapse without stop");

	// endless looping never reports a stop
	a_endless_runs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.loops_left[LOOP_WIDTH-1] |-> !result.stopped)
		else $error("stopped with endless loops");

endmodule

bind looping_playhead lph_checker u_lph_checker (.*);

[tb/tb_looping_playhead.sv]
// self-checking testbench for the looping playhead: directed and random words
`timescale 1ns / 100ps

module tb_looping_playhead;

	import lph_pkg::*;

	// action code that the block leaves unused apart from the range clamp
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam longint T_MAX       = TIME_MAX;
	localparam longint T_MIN       = TIME_MIN;
	localparam int     CYCLE_LIMIT = 1000000;
	localparam int     LONG_HOLD   = 400;
	localparam int     MAX_REPORTS = 10;

	// one full register set as the block sees it after the writes
	typedef struct {
		time_t  range_a;
		time_t  range_b;
		time_t  loop_first;
		time_t  loop_last;
		loop_t  count;
		speed_t speed;
	} setup_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       wr_en        = 1'b0;
	logic [REG_INDEX_WIDTH-1:0] wr_index     = '0;
	logic [CFG_WIDTH-1:0]       wr_data      = '0;
	logic                       item_valid   = 1'b0;
	logic                       item_ready;
	item_t                      item         = '0;
	logic                       result_valid;
	logic                       result_ready = 1'b0;
	result_t                    result;

	// shadow of the block: registers, internal time and loop count
	setup_t  live_setup;
	longint  pos_now;
	longint  loops_now;

	result_t pending_results[$];
	int      mismatches      = 0;
	int      cycles          = 0;
	int      burst_left      = 0;
	int      hold_request    = 0;

	// window that the random words of a phase aim at
	longint  span_lo;
	longint  span_hi;
	longint  span_half;

	looping_playhead dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run-away guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------- prediction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// reflect a time within [s, e]; reverse play keeps its time this way round
	function automatic longint fold(longint t, longint s, longint e);
		return e - (t - s);
	endfunction

	// step times Q8.8 speed, magnitude truncated toward zero, then saturated
	function automatic longint scaled_step(time_t step, speed_t spd);
		longint a;
		longint b;
		longint q;
		bit     neg;
		a   = step;
		b   = spd;
		neg = (a < 0) != (b < 0);
		if (a < 0)
			a = -a;
		if (b < 0)
			b = -b;
		q = (a * b) >>> SPEED_FRAC;
		if (!neg)
			return (q > T_MAX) ? T_MAX : q;
		return (q > T_MAX + 1) ? T_MIN : -q;
	endfunction

	// works out the result word of one accepted word and moves the shadow on
	function automatic result_t next_playhead(item_t w);
		longint  a, b, lf, ll, lo, hi;
		longint  s, e, ls, le, nls;
		longint  t, old, loops, len;
		bit      rev;
		bit      coll;
		result_t r;
		a  = live_setup.range_a;
		b  = live_setup.range_b;
		lf = live_setup.loop_first;
		ll = live_setup.loop_last;
		lo = (lf < ll) ? lf : ll;
		hi = (lf < ll) ? ll : lf;
		s  = (a < b) ? a : b;
		e  = (a < b) ? b : a;
		// loop points are pulled into the range, so a loop outside it has no length
		ls  = clampl(lo, s, e);
		le  = clampl(hi, s, e);
		rev = lf > ll;
		if (rev) begin
			nls = fold(le, s, e);
			le  = fold(ls, s, e);
			ls  = nls;
		end
		old   = pos_now;
		// the range may have moved since the last word
		t     = clampl(old, s, e);
		loops = loops_now;
		coll  = 1'b0;
		unique case (w.action)
			ACT_ADVANCE: begin
				t = clampl(t + scaled_step(w.step, live_setup.speed), T_MIN, T_MAX);
				if (loops == 0) begin
					if (t > e)
						t = e;
				end else if (t > le) begin
					len = le - ls;
					if (len == 0) begin
						t     = e;
						loops = 0;
						coll  = 1'b1;
					end else begin
						t = ls + (t - le) % len;
					end
					if (loops > 0)
						loops--;
				end
				if (t < s)
					t = s;
			end
			ACT_SEEK, ACT_RESTART: begin
				t = clampl(w.position, s, e);
				if (rev)
					t = fold(t, s, e);
				if (w.action == ACT_RESTART)
					loops = live_setup.count;
			end
			default: ;
		endcase
		pos_now      = t;
		loops_now    = loops;
		r.play_time  = time_t'(rev ? fold(t, s, e) : t);
		r.loops_left = loop_t'(loops);
		r.stopped    = (t >= e) && (loops == 0);
		r.changed    = t != old;
		r.collapsed  = coll;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin : check_words
		result_t want;
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("stray result word at %0t: %p", $realtime, result);
			end else begin
				want = pending_results.pop_front();
				if (result.play_time !== want.play_time ||
				    result.loops_left !== want.loops_left ||
				    result.stopped !== want.stopped ||
				    result.changed !== want.changed ||
				    result.collapsed !== want.collapsed) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch at %0t: expected %p, got %p",
							$realtime, want, result);
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// stalls come in runs of one style; a requested hold-off takes precedence
	initial begin : receiver
		int mode;
		int run;
		int phase;
		int n;
		mode  = 0;
		run   = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				n            = hold_request;
				hold_request = 0;
				result_ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				if (run == 0) begin
					mode = $urandom_range(0, 3);
					run  = $urandom_range(1, 60);
				end
				run--;
				phase++;
				unique case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= 1'($urandom_range(0, 1));
					2: result_ready <= ($urandom_range(0, 3) == 0);
					default: result_ready <= (phase % 3) != 0;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// offers one word, with bursts and gaps, and records its result on acceptance
	task automatic send_word(input item_t w);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (!item_ready);
		pending_results.push_back(next_playhead(w));
	endtask

	// lets every outstanding word come back before the registers change
	task automatic wait_idle(input int settle);
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic put_reg(input reg_index_t idx, input logic [CFG_WIDTH-1:0] v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		unique case (idx)
			REG_RANGE_START: live_setup.range_a    = time_t'(v);
			REG_RANGE_END:   live_setup.range_b    = time_t'(v);
			REG_LOOP_FIRST:  live_setup.loop_first = time_t'(v);
			REG_LOOP_LAST:   live_setup.loop_last  = time_t'(v);
			REG_LOOP_COUNT:  live_setup.count      = loop_t'(v);
			REG_PLAY_SPEED:  live_setup.speed      = speed_t'(v);
			default: ;
		endcase
	endtask

	task automatic apply_setup(input setup_t c);
		put_reg(REG_RANGE_START, CFG_WIDTH'(c.range_a));
		put_reg(REG_RANGE_END,   CFG_WIDTH'(c.range_b));
		put_reg(REG_LOOP_FIRST,  CFG_WIDTH'(c.loop_first));
		put_reg(REG_LOOP_LAST,   CFG_WIDTH'(c.loop_last));
		put_reg(REG_LOOP_COUNT,  CFG_WIDTH'(c.count));
		put_reg(REG_PLAY_SPEED,  CFG_WIDTH'(c.speed));
		wr_en <= 1'b0;
	endtask

	function automatic item_t mk(logic [1:0] act, time_t step, time_t position);
		item_t w;
		w.action   = act;
		w.step     = step;
		w.position = position;
		return w;
	endfunction

	function automatic setup_t mk_setup(time_t a, time_t b, time_t lf, time_t ll,
		loop_t cnt, speed_t spd);
		setup_t c;
		c.range_a    = a;
		c.range_b    = b;
		c.loop_first = lf;
		c.loop_last  = ll;
		c.count      = cnt;
		c.speed      = spd;
		return c;
	endfunction

	// whole units to Q16.16
	function automatic time_t q16(int n);
		return time_t'(longint'(n) * 65536);
	endfunction

	function automatic longint rand_span(longint lo, longint hi);
		longint unsigned r;
		r = {$urandom(), $urandom()};
		return lo + longint'(r % longint'(hi - lo + 1));
	endfunction

	function automatic time_t rand_time(longint lo, longint hi);
		return time_t'(clampl(rand_span(lo, hi), T_MIN, T_MAX));
	endfunction

	// ---------------------------------------------------------------- random words

	function automatic setup_t pick_setup();
		setup_t c;
		longint centre;
		longint ra, rb;
		int     r;
		if ($urandom_range(0, 9) == 0) begin
			// anything at all, ends in either order
			c.range_a    = $urandom();
			c.range_b    = $urandom();
			c.loop_first = $urandom();
			c.loop_last  = $urandom();
			span_lo      = T_MIN;
			span_hi      = T_MAX;
			span_half    = longint'(1) <<< 30;
		end else begin
			centre    = ($urandom_range(0, 8) == 0) ? 0 : rand_span(-(1 <<< 29), 1 <<< 29);
			span_half = longint'(1) <<< $urandom_range(4, 26);
			ra        = centre - span_half + rand_span(0, span_half / 4);
			rb        = centre + span_half - rand_span(0, span_half / 4);
			span_lo   = ra;
			span_hi   = rb;
			if ($urandom_range(0, 1)) begin
				c.range_a = time_t'(ra);
				c.range_b = time_t'(rb);
			end else begin
				c.range_a = time_t'(rb);
				c.range_b = time_t'(ra);
			end
			// loop points may stick out of the range; order picks the direction
			c.loop_first = rand_time(centre - span_half - span_half / 4,
				centre + span_half + span_half / 4);
			c.loop_last  = ($urandom_range(0, 9) == 0) ? c.loop_first :
				rand_time(centre - span_half - span_half / 4,
				centre + span_half + span_half / 4);
		end
		r = $urandom_range(0, 19);
		if (r < 12)
			c.count = loop_t'($urandom_range(0, 4));
		else if (r < 17)
			c.count = loop_t'(-1);
		else if (r == 17)
			c.count = loop_t'(32767);
		else if (r == 18)
			c.count = loop_t'($urandom_range(0, 32767));
		else
			c.count = '0;
		r = $urandom_range(0, 9);
		if (r < 3)
			c.speed = speed_t'(256);
		else if (r < 7)
			c.speed = ($urandom_range(0, 4) == 0) ?
				speed_t'(-int'($urandom_range(1, 1024))) :
				speed_t'($urandom_range(1, 1024));
		else if (r == 7)
			c.speed = speed_t'($urandom());
		else if (r == 8)
			c.speed = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		else
			c.speed = '0;
		return c;
	endfunction

	function automatic time_t pick_step();
		int     r;
		longint cap;
		r   = $urandom_range(0, 19);
		cap = span_half >>> $urandom_range(0, 4);
		if (r == 0)
			return $urandom();
		if (r == 1)
			return $urandom_range(0, 1) ? TIME_MAX : TIME_MIN;
		if (r < 5)
			return rand_time(-cap, 0);
		return rand_time(0, cap);
	endfunction

	function automatic time_t pick_position();
		if ($urandom_range(0, 4) == 0)
			return $urandom();
		return rand_time(span_lo - span_half / 2, span_hi + span_half / 2);
	endfunction

	function automatic item_t pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return mk(ACT_ADVANCE, pick_step(), $urandom());
		if (r < 83)
			return mk(ACT_SEEK, $urandom(), pick_position());
		if (r < 95)
			return mk(ACT_RESTART, $urandom(), pick_position());
		return mk(ACT_UNUSED, $urandom(), $urandom());
	endfunction

	// ---------------------------------------------------------------- tests

	// registers at their defaults: run to the end, hold there, seek to both extremes, restart
	task automatic test_reset_defaults();
		send_word(mk(ACT_ADVANCE, '0, '0));
		send_word(mk(ACT_ADVANCE, q16(1), '0));
		send_word(mk(ACT_ADVANCE, q16(1), '0));
		send_word(mk(ACT_SEEK, '0, TIME_MIN));
		send_word(mk(ACT_SEEK, '0, TIME_MAX));
		send_word(mk(ACT_RESTART, '0, -32768));
		wait_idle(8);
	endtask

	// range ends given the wrong way round; wrap, saturating add, hold at the end
	task automatic test_loop_wrap();
		apply_setup(mk_setup(q16(10), '0, q16(2), q16(6), loop_t'(2), speed_t'(256)));
		// unused action only re-clamps the time into the new range
		send_word(mk(ACT_UNUSED, TIME_MAX, TIME_MIN));
		send_word(mk(ACT_RESTART, '0, '0));
		send_word(mk(ACT_ADVANCE, q16(7), '0));
		send_word(mk(ACT_ADVANCE, TIME_MAX, '0));
		send_word(mk(ACT_ADVANCE, q16(20), '0));
		// product reaches its low extreme and the time is held at the range start
		send_word(mk(ACT_ADVANCE, TIME_MIN, '0));
		wait_idle(8);
	endtask

	// loop points swapped: mirrored play, endless loops, negative speed
	task automatic test_reverse();
		apply_setup(mk_setup('0, q16(10), q16(8), q16(3), loop_t'(-1), speed_t'(-256)));
		send_word(mk(ACT_RESTART, '0, q16(4)));
		send_word(mk(ACT_ADVANCE, -q16(3), '0));
		send_word(mk(ACT_ADVANCE, -q16(20), '0));
		send_word(mk(ACT_SEEK, '0, q16(9)));
		wait_idle(8);
	endtask

	// a loop of no length, then one lying wholly outside the range
	task automatic test_zero_length();
		apply_setup(mk_setup('0, q16(10), q16(5), q16(5), loop_t'(3), speed_t'(256)));
		send_word(mk(ACT_RESTART, '0, q16(2)));
		send_word(mk(ACT_ADVANCE, q16(4), '0));
		wait_idle(8);
		apply_setup(mk_setup('0, q16(10), q16(20), q16(30), loop_t'(1), speed_t'(256)));
		send_word(mk(ACT_RESTART, '0, '0));
		send_word(mk(ACT_ADVANCE, q16(15), '0));
		wait_idle(8);
	endtask

	// full 32-bit range with the largest count and both speed extremes
	task automatic test_extremes();
		apply_setup(mk_setup(TIME_MIN, TIME_MAX, TIME_MAX, TIME_MIN, loop_t'(32767),
			16'sh7fff));
		send_word(mk(ACT_RESTART, '0, TIME_MIN));
		send_word(mk(ACT_ADVANCE, TIME_MAX, '0));
		wait_idle(8);
		apply_setup(mk_setup(TIME_MIN, TIME_MAX, TIME_MIN, TIME_MAX, loop_t'(32767),
			16'sh8000));
		send_word(mk(ACT_ADVANCE, TIME_MIN, '0));
		wait_idle(8);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		apply_setup(mk_setup('0, q16(16), q16(4), q16(12), loop_t'(-1), speed_t'(256)));
		send_word(mk(ACT_RESTART, '0, q16(1)));
		hold_request = LONG_HOLD;
		burst_left   = 40;
		repeat (40)
			send_word(mk(ACT_ADVANCE, rand_time(0, longint'(q16(6))), '0));
		wait_idle(8);
	endtask

	// random register sets, each opened by a restart so the loop count is live
	task automatic test_random_phases();
		int n;
		repeat (12) begin
			apply_setup(pick_setup());
			send_word(mk(ACT_RESTART, $urandom(), pick_position()));
			n = $urandom_range(90, 150);
			repeat (n)
				send_word(pick_word());
			wait_idle(8);
		end
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		live_setup = mk_setup(RANGE_START_RST, RANGE_END_RST, LOOP_FIRST_RST,
			LOOP_LAST_RST, LOOP_COUNT_RST, PLAY_SPEED_RST);
		pos_now    = RANGE_START_RST;
		loops_now  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_loop_wrap();
		test_reverse();
		test_zero_length();
		test_extremes();
		test_backpressure();
		test_random_phases();

		// let any stray word show up before the verdict
		wait_idle(40);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
